// File: design/urf_pkg.sv
package urf_pkg;

    // One input item: a bus read, a bus write or a received character.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [11:0] offset;
        logic [31:0] wdata;
        logic [7:0]  rx_char;
    } urf_in_t;

    // One result item.
    typedef struct packed {
        logic [31:0] rdata;
        logic        tx_valid;
        logic [7:0]  tx_char;
    } urf_out_t;

    // Item opcodes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    // Byte offsets with side effects, mode-dependent decoding or a fixed read value.
    localparam logic [11:0] OFS_DATA = 12'h000;
    localparam logic [11:0] OFS_IER  = 12'h004;
    localparam logic [11:0] OFS_FCR  = 12'h008;
    localparam logic [11:0] OFS_SYSC = 12'h054;
    localparam logic [11:0] OFS_SYSS = 12'h058;

    // Word indexes of registers held apart or with a nonzero reset value.
    localparam logic [9:0] WORD_LCR  = 10'd3;
    localparam logic [9:0] WORD_LSR  = 10'd5;
    localparam logic [9:0] WORD_MDR1 = 10'd8;
    localparam logic [9:0] WORD_SYSS = 10'd22;

    // LSR bits.
    localparam logic [31:0] LSR_DR        = 32'h0000_0001;
    localparam logic [31:0] LSR_OE        = 32'h0000_0002;
    localparam logic [31:0] LSR_THRE_TEMT = 32'h0000_0060;

    // Fixed read values and control bit positions.
    localparam logic [31:0] IIR_VALUE      = 32'h0000_0001;
    localparam logic [31:0] SYSS_VALUE     = 32'h0000_0001;
    localparam logic [31:0] MDR1_RESET     = 32'h0000_0007;
    localparam logic [7:0]  LCR_CFG_B      = 8'hBF;
    localparam int          LCR_CFG_A_BIT  = 7;
    localparam int          FCR_RX_CLR_BIT = 1;
    localparam int          FCR_TX_CLR_BIT = 2;
    localparam int          SYSC_RESET_BIT = 1;

    // Register access modes selected by LCR.
    typedef enum logic [2:0] {
        MODE_OPER  = 3'b001,
        MODE_CFG_A = 3'b010,
        MODE_CFG_B = 3'b100
    } urf_mode_t;

    // Reset value of a register word.
    function automatic logic [31:0] word_reset_value(input logic [9:0] idx);
        logic [31:0] value;
        case (idx)
            WORD_LSR:  value = LSR_THRE_TEMT;
            WORD_MDR1: value = MDR1_RESET;
            WORD_SYSS: value = SYSS_VALUE;
            default:   value = '0;
        endcase
        return value;
    endfunction

endpackage

// File: design/urf_ram.sv
module urf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port; a read in the same
    // cycle as a write to the same address returns the old contents.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/uart_register_file_rx_fifo.sv
// UART register file with a receive FIFO. Each transfer on the s_ channel is
// a bus read, a bus write or a character received from the line, and it gives
// exactly one result transfer on the m_ channel. One item is taken per clock
// while s_ready is high. An item passes through an input register, one pass of
// decode logic and an output register, and its result is offered on m_valid
// from the output register until it transfers. The generic register words and
// the receive FIFO each sit in a RAM read when the item is accepted, with a
// forwarding register for a write that lands in between. After reset, and
// after a soft reset through SYSC, the register RAM is rewritten word by word
// with its reset values, during which s_ready is low. LCR and LSR live in
// flip-flops because reads, writes and received characters can all read or
// update them.
module uart_register_file_rx_fifo #(
    parameter int FIFO_DEPTH = 64,
    parameter int REG_WORDS  = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  urf_pkg::urf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output urf_pkg::urf_out_t m_data
);

    import urf_pkg::*;

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int AW     = $clog2(REG_WORDS);

    // Pipeline registers and the decoded result.
    logic     in_valid_reg;
    urf_in_t  in_item_reg;
    logic     out_valid_reg;
    urf_out_t out_item_reg;
    urf_out_t result;

    // Register RAM clearing pass.
    logic          clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;

    // Architectural state kept in flip-flops.
    logic [31:0]       lcr_reg, lcr_next;
    logic [31:0]       lsr_reg, lsr_next;
    logic [15:0]       div_reg, div_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Forwarding registers for reads that race a write.
    logic        wfwd_hit_reg;
    logic [31:0] wfwd_data_reg;
    logic        qfwd_hit_reg;
    logic [7:0]  qfwd_data_reg;

    // RAM ports.
    logic          word_we;
    logic [AW-1:0] word_waddr;
    logic [31:0]   word_wdata;
    logic [31:0]   word_q;
    logic [AW-1:0] word_raddr;
    logic          fifo_we;
    logic [7:0]    fifo_q;

    // Handshake and decode signals.
    logic        s_accept;
    logic        advance;
    logic        process;
    logic        soft_reset;
    logic        proc_we;
    logic [9:0]  word_idx;
    logic [9:0]  s_word;
    logic        in_range;
    logic [31:0] word_val;
    logic [31:0] stored_val;
    logic [7:0]  fifo_char;
    urf_mode_t   mode;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;

    // Handshake: new items enter as held ones move on, unless a clear is due.
    assign advance  = !out_valid_reg || m_ready;
    assign process  = in_valid_reg && advance;
    assign s_ready  = !clr_busy_reg && (!in_valid_reg || (advance && !soft_reset));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_item_reg;

    // Field decode of the held item and of the incoming item.
    assign word_idx = in_item_reg.offset[11:2];
    assign s_word   = s_data.offset[11:2];
    assign in_range = {1'b0, word_idx} < 11'(REG_WORDS);
    assign word_val = wfwd_hit_reg ? wfwd_data_reg : word_q;
    assign fifo_char = qfwd_hit_reg ? qfwd_data_reg : fifo_q;

    always_comb begin
        if (word_idx == WORD_LCR) begin
            stored_val = lcr_reg;
        end else if (word_idx == WORD_LSR) begin
            stored_val = lsr_reg;
        end else begin
            stored_val = word_val;
        end
    end

    // Access mode from the low byte of LCR.
    always_comb begin
        if (lcr_reg[7:0] == LCR_CFG_B) begin
            mode = MODE_CFG_B;
        end else if (lcr_reg[LCR_CFG_A_BIT]) begin
            mode = MODE_CFG_A;
        end else begin
            mode = MODE_OPER;
        end
    end

    // Ring pointer increments.
    assign head_inc = (head_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    // Main decode: state updates and the result of the held item.
    always_comb begin
        lcr_next   = lcr_reg;
        lsr_next   = lsr_reg;
        div_next   = div_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        result     = '0;
        proc_we    = 1'b0;
        fifo_we    = 1'b0;
        soft_reset = 1'b0;
        if (process) begin
            case (in_item_reg.opcode)
                OP_READ: begin
                    case (in_item_reg.offset)
                        OFS_DATA: begin
                            if (mode == MODE_CFG_A) begin
                                result.rdata = {24'b0, div_reg[7:0]};
                            end else if (fill_reg != '0) begin
                                result.rdata = {24'b0, fifo_char};
                                tail_next    = tail_inc;
                                fill_next    = fill_reg - 1'b1;
                                if (fill_reg == FILL_W'(1)) begin
                                    lsr_next = lsr_reg & ~LSR_DR;
                                end
                            end
                        end
                        OFS_IER: begin
                            if (mode == MODE_CFG_A) begin
                                result.rdata = {24'b0, div_reg[15:8]};
                            end else begin
                                result.rdata = stored_val;
                            end
                        end
                        OFS_FCR: begin
                            result.rdata = (mode == MODE_CFG_B) ? stored_val : IIR_VALUE;
                        end
                        OFS_SYSS: begin
                            result.rdata = SYSS_VALUE;
                        end
                        default: begin
                            result.rdata = in_range ? stored_val : '0;
                        end
                    endcase
                end
                OP_WRITE: begin
                    case (in_item_reg.offset)
                        OFS_DATA: begin
                            if (mode == MODE_CFG_A) begin
                                div_next[7:0] = in_item_reg.wdata[7:0];
                            end else begin
                                result.tx_valid = 1'b1;
                                result.tx_char  = in_item_reg.wdata[7:0];
                                lsr_next        = lsr_reg | LSR_THRE_TEMT;
                            end
                        end
                        OFS_IER: begin
                            if (mode == MODE_CFG_A) begin
                                div_next[15:8] = in_item_reg.wdata[7:0];
                            end else begin
                                proc_we = 1'b1;
                            end
                        end
                        OFS_FCR: begin
                            if (mode == MODE_CFG_B) begin
                                proc_we = 1'b1;
                            end else begin
                                if (in_item_reg.wdata[FCR_RX_CLR_BIT]) begin
                                    head_next = '0;
                                    tail_next = '0;
                                    fill_next = '0;
                                    lsr_next  = lsr_next & ~LSR_DR;
                                end
                                if (in_item_reg.wdata[FCR_TX_CLR_BIT]) begin
                                    lsr_next = lsr_next | LSR_THRE_TEMT;
                                end
                            end
                        end
                        OFS_SYSC: begin
                            if (in_item_reg.wdata[SYSC_RESET_BIT]) begin
                                soft_reset = 1'b1;
                            end else begin
                                proc_we = 1'b1;
                            end
                        end
                        default: begin
                            if (in_range) begin
                                if (word_idx == WORD_LCR) begin
                                    lcr_next = in_item_reg.wdata;
                                end else if (word_idx == WORD_LSR) begin
                                    lsr_next = in_item_reg.wdata;
                                end else begin
                                    proc_we = 1'b1;
                                end
                            end
                        end
                    endcase
                end
                OP_RX: begin
                    if (fill_reg == FILL_W'(FIFO_DEPTH)) begin
                        lsr_next = lsr_reg | LSR_OE;
                    end else begin
                        fifo_we   = 1'b1;
                        head_next = head_inc;
                        fill_next = fill_reg + 1'b1;
                        lsr_next  = lsr_reg | LSR_DR;
                    end
                end
                default: begin
                end
            endcase
        end

        // A soft reset returns the flip-flop state to its reset values.
        if (soft_reset) begin
            lcr_next  = '0;
            lsr_next  = LSR_THRE_TEMT;
            div_next  = '0;
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
    end

    // Register RAM write port: the clearing pass or the held item.
    assign word_we    = clr_busy_reg || proc_we;
    assign word_waddr = clr_busy_reg ? clr_idx_reg : word_idx[AW-1:0];
    assign word_wdata = clr_busy_reg ? word_reset_value(10'(clr_idx_reg))
                                     : in_item_reg.wdata;
    assign word_raddr = s_word[AW-1:0];

    urf_ram #(
        .WIDTH (32),
        .DEPTH (REG_WORDS),
        .ADDR_W(AW)
    ) u_word_ram (
        .clk    (aclk),
        .wr_en  (word_we),
        .wr_addr(word_waddr),
        .wr_data(word_wdata),
        .rd_en  (s_accept),
        .rd_addr(word_raddr),
        .rd_data(word_q)
    );

    // Receive FIFO store, read at the tail the accepted item will see.
    urf_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH),
        .ADDR_W(PTR_W)
    ) u_fifo_ram (
        .clk    (aclk),
        .wr_en  (fifo_we),
        .wr_addr(head_reg),
        .wr_data(in_item_reg.rx_char),
        .rd_en  (s_accept),
        .rd_addr(tail_next),
        .rd_data(fifo_q)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            lcr_reg       <= '0;
            lsr_reg       <= LSR_THRE_TEMT;
            div_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            if (process) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (soft_reset) begin
                clr_busy_reg <= 1'b1;
                clr_idx_reg  <= '0;
            end else if (clr_busy_reg) begin
                if (clr_idx_reg == AW'(REG_WORDS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
            end
            lcr_reg  <= lcr_next;
            lsr_reg  <= lsr_next;
            div_reg  <= div_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // Payload and forwarding registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg   <= s_data;
            wfwd_hit_reg  <= word_we && (word_waddr == word_raddr);
            wfwd_data_reg <= word_wdata;
            qfwd_hit_reg  <= fifo_we && (head_reg == tail_next);
            qfwd_data_reg <= in_item_reg.rx_char;
        end
        if (process) begin
            out_item_reg <= result;
        end
    end

endmodule

// File: design/urf_checker.sv
module urf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input urf_pkg::urf_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input urf_pkg::urf_out_t m_data
);

    // A stalled input transfer keeps its valid and payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transfer dropped or changed while stalled");

    // A stalled result keeps its valid and payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transfer dropped or changed while stalled");

    // Reset starts the register clearing pass, which holds off input.
    assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken right after reset");

    // With the result side open, an accepted item is followed by a result on m_valid.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 (m_ready && aresetn) |=> m_valid)
        else $error("result missing after accepted item");

    // No character is shown unless a transmit is flagged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.tx_valid |-> m_data.tx_char == 8'h00)
        else $error("transmit character without transmit flag");

endmodule

bind uart_register_file_rx_fifo urf_checker u_urf_checker (.*);

// File: tb/sv/tb_uart_register_file_rx_fifo.sv
`timescale 1ns / 100ps

module tb_uart_register_file_rx_fifo;
    import urf_pkg::*;

    localparam int FIFO_DEPTH      = 64;
    localparam int REG_WORDS       = 32;
    localparam int ITEM_TARGET     = 1700;
    localparam int QUIET_TAIL      = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 10;

    // Opcode that the block must treat as a no-op.
    localparam logic [1:0] OP_NONE = 2'd3;

    // Offsets of plain registers, plus word indexes used by the shadow model.
    localparam logic [11:0] OFS_LCR  = {WORD_LCR, 2'b00};
    localparam logic [11:0] OFS_MCR  = 12'h010;
    localparam logic [11:0] OFS_LSR  = {WORD_LSR, 2'b00};
    localparam logic [11:0] OFS_MSR  = 12'h018;
    localparam logic [11:0] OFS_SPR  = 12'h01C;
    localparam logic [11:0] OFS_MDR1 = {WORD_MDR1, 2'b00};
    localparam logic [11:0] OFS_SCR  = 12'h040;
    localparam int WORD_IER  = OFS_IER / 4;
    localparam int WORD_FCR  = OFS_FCR / 4;
    localparam int WORD_SYSC = OFS_SYSC / 4;
    localparam int FCR_ENABLE_BIT = 0;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    urf_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    urf_out_t  m_data;

    // Shadow copy of the register file and receive FIFO.
    logic [31:0] reg_shadow [REG_WORDS];
    logic [7:0]  rx_shadow [FIFO_DEPTH];
    int unsigned rx_wr_ptr;
    int unsigned rx_rd_ptr;
    int unsigned rx_level;
    logic [15:0] divisor_shadow;
    logic        fifo_enable_shadow;

    urf_out_t expected_results [$];
    int       error_count = 0;
    int       items_sent = 0;
    int       quiet_cycles = 0;
    bit       idle_on = 1'b1;
    bit       hold_off_req = 1'b0;

    uart_register_file_rx_fifo u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Free-running clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Puts the shadow model into its power-on state. The FIFO storage is kept.
    function automatic void reset_shadow();
        for (int i = 0; i < REG_WORDS; i++) begin
            reg_shadow[i] = '0;
        end
        reg_shadow[WORD_LSR]  = LSR_THRE_TEMT;
        reg_shadow[WORD_MDR1] = MDR1_RESET;
        reg_shadow[WORD_SYSS] = SYSS_VALUE;
        rx_wr_ptr = 0;
        rx_rd_ptr = 0;
        rx_level = 0;
        divisor_shadow = '0;
        fifo_enable_shadow = 1'b0;
    endfunction

    // Access mode selected by the low byte of LCR.
    function automatic urf_mode_t shadow_mode();
        logic [7:0] lcr;
        lcr = reg_shadow[WORD_LCR][7:0];
        if (lcr == LCR_CFG_B) begin
            return MODE_CFG_B;
        end
        if (lcr[LCR_CFG_A_BIT]) begin
            return MODE_CFG_A;
        end
        return MODE_OPER;
    endfunction

    // Applies one accepted item to the shadow model and returns its result.
    function automatic urf_out_t predict_uart(input urf_in_t item);
        urf_out_t  res;
        urf_mode_t mode;
        int        word;
        res = '0;
        mode = shadow_mode();
        word = int'(item.offset[11:2]);
        case (item.opcode)
            OP_READ: begin
                case (item.offset)
                    OFS_DATA: begin
                        if (mode == MODE_CFG_A) begin
                            res.rdata = {24'h0, divisor_shadow[7:0]};
                        end else if (rx_level > 0) begin
                            res.rdata = {24'h0, rx_shadow[rx_rd_ptr]};
                            rx_rd_ptr = (rx_rd_ptr + 1) % FIFO_DEPTH;
                            rx_level--;
                            if (rx_level == 0) begin
                                reg_shadow[WORD_LSR] &= ~LSR_DR;
                            end
                        end
                    end
                    OFS_IER: begin
                        if (mode == MODE_CFG_A) begin
                            res.rdata = {24'h0, divisor_shadow[15:8]};
                        end else begin
                            res.rdata = reg_shadow[WORD_IER];
                        end
                    end
                    OFS_FCR: begin
                        res.rdata = (mode == MODE_CFG_B) ? reg_shadow[WORD_FCR] : IIR_VALUE;
                    end
                    OFS_SYSS: begin
                        res.rdata = SYSS_VALUE;
                    end
                    default: begin
                        if (word < REG_WORDS) begin
                            res.rdata = reg_shadow[word];
                        end
                    end
                endcase
            end
            OP_WRITE: begin
                case (item.offset)
                    OFS_DATA: begin
                        if (mode == MODE_CFG_A) begin
                            divisor_shadow[7:0] = item.wdata[7:0];
                        end else begin
                            res.tx_valid = 1'b1;
                            res.tx_char = item.wdata[7:0];
                            reg_shadow[WORD_LSR] |= LSR_THRE_TEMT;
                        end
                    end
                    OFS_IER: begin
                        if (mode == MODE_CFG_A) begin
                            divisor_shadow[15:8] = item.wdata[7:0];
                        end else begin
                            reg_shadow[WORD_IER] = item.wdata;
                        end
                    end
                    OFS_FCR: begin
                        if (mode == MODE_CFG_B) begin
                            reg_shadow[WORD_FCR] = item.wdata;
                        end else begin
                            fifo_enable_shadow = item.wdata[FCR_ENABLE_BIT];
                            if (item.wdata[FCR_RX_CLR_BIT]) begin
                                rx_wr_ptr = 0;
                                rx_rd_ptr = 0;
                                rx_level = 0;
                                reg_shadow[WORD_LSR] &= ~LSR_DR;
                            end
                            if (item.wdata[FCR_TX_CLR_BIT]) begin
                                reg_shadow[WORD_LSR] |= LSR_THRE_TEMT;
                            end
                        end
                    end
                    OFS_SYSC: begin
                        reg_shadow[WORD_SYSC] = item.wdata;
                        if (item.wdata[SYSC_RESET_BIT]) begin
                            reset_shadow();
                        end
                    end
                    default: begin
                        if (word < REG_WORDS) begin
                            reg_shadow[word] = item.wdata;
                        end
                    end
                endcase
            end
            OP_RX: begin
                if (rx_level >= FIFO_DEPTH) begin
                    reg_shadow[WORD_LSR] |= LSR_OE;
                end else begin
                    rx_shadow[rx_wr_ptr] = item.rx_char;
                    rx_wr_ptr = (rx_wr_ptr + 1) % FIFO_DEPTH;
                    rx_level++;
                    reg_shadow[WORD_LSR] |= LSR_DR;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Offers one item, optionally after an idle burst, and records its result
    // once the transfer happens.
    task automatic send_item(input urf_in_t item);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_uart(item));
        items_sent++;
    endtask

    task automatic rd_reg(input logic [11:0] ofs);
        urf_in_t item;
        item.opcode = OP_READ;
        item.offset = ofs;
        item.wdata = $urandom;
        item.rx_char = 8'($urandom_range(0, 255));
        send_item(item);
    endtask

    task automatic wr_reg(input logic [11:0] ofs, input logic [31:0] data);
        urf_in_t item;
        item.opcode = OP_WRITE;
        item.offset = ofs;
        item.wdata = data;
        item.rx_char = 8'($urandom_range(0, 255));
        send_item(item);
    endtask

    task automatic rx_char_in(input logic [7:0] ch);
        urf_in_t item;
        item.opcode = OP_RX;
        item.offset = 12'($urandom_range(0, 4095));
        item.wdata = $urandom;
        item.rx_char = ch;
        send_item(item);
    endtask

    // Mostly named registers, sometimes unaligned or out-of-window offsets.
    function automatic logic [11:0] pick_offset();
        case ($urandom_range(0, 15))
            0:       return OFS_DATA;
            1:       return OFS_IER;
            2:       return OFS_FCR;
            3:       return OFS_LCR;
            4:       return OFS_MCR;
            5:       return OFS_LSR;
            6:       return OFS_MSR;
            7:       return OFS_SPR;
            8:       return OFS_MDR1;
            9:       return OFS_SCR;
            10:      return OFS_SYSS;
            11, 12:  return 12'($urandom_range(0, 127));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // One access to the mode-dependent window at offsets 0x00 to 0x08.
    task automatic mode_window_access();
        logic [11:0] ofs;
        case ($urandom_range(0, 2))
            0:       ofs = OFS_DATA;
            1:       ofs = OFS_IER;
            default: ofs = OFS_FCR;
        endcase
        if ($urandom_range(0, 1) == 0) begin
            rd_reg(ofs);
        end else begin
            wr_reg(ofs, $urandom);
        end
    endtask

    task automatic test_reset_values();
        rd_reg(OFS_LSR);
        rd_reg(OFS_MDR1);
        rd_reg(OFS_SYSS);
        // RHR read with nothing queued returns zero.
        rd_reg(OFS_DATA);
    endtask

    task automatic test_register_access();
        urf_in_t item;
        wr_reg(OFS_DATA, 32'hFFFF_FFA5);
        wr_reg(OFS_SCR, 32'hFFFF_FFFF);
        rd_reg(OFS_SCR);
        // Past the register words: the write is dropped and the read gives zero.
        wr_reg(12'hFFF, 32'hFFFF_FFFF);
        rd_reg(12'hFFF);
        // Unaligned offsets land on the word directly.
        wr_reg(12'h003, 32'h0000_1234);
        rd_reg(12'h001);
        item.opcode = OP_NONE;
        item.offset = OFS_DATA;
        item.wdata = 32'hFFFF_FFFF;
        item.rx_char = 8'hFF;
        send_item(item);
    endtask

    task automatic test_access_modes();
        wr_reg(OFS_LCR, 32'h0000_0080);
        wr_reg(OFS_DATA, 32'h0000_00FF);
        wr_reg(OFS_IER, 32'h0000_00AB);
        rd_reg(OFS_DATA);
        rd_reg(OFS_IER);
        wr_reg(OFS_LCR, {24'h0, LCR_CFG_B});
        wr_reg(OFS_FCR, 32'h0000_0010);
        rd_reg(OFS_FCR);
        wr_reg(OFS_LCR, 32'h0000_0000);
        rd_reg(OFS_FCR);
    endtask

    task automatic test_rx_fifo();
        rx_char_in(8'h00);
        rx_char_in(8'hFF);
        rd_reg(OFS_LSR);
        rd_reg(OFS_DATA);
        // Popping the last character clears data ready.
        rd_reg(OFS_DATA);
        rd_reg(OFS_LSR);
        rx_char_in(8'h5A);
        wr_reg(OFS_FCR, 32'h0000_0007);
        rd_reg(OFS_LSR);
    endtask

    task automatic test_soft_reset();
        wr_reg(OFS_SYSC, 32'h0000_0002);
        rd_reg(OFS_SYSC);
        wr_reg(OFS_SYSS, 32'h0000_FFFF);
        rd_reg(OFS_SYSS);
    endtask

    // The receiver holds off while characters keep coming, so the block
    // backs up; the FIFO then overflows and is read back in full.
    task automatic test_backpressure();
        wr_reg(OFS_LCR, 32'h0000_0000);
        wr_reg(OFS_FCR, 32'h0000_0002);
        hold_off_req = 1'b1;
        repeat (FIFO_DEPTH + 8) rx_char_in(8'($urandom_range(0, 255)));
        rd_reg(OFS_LSR);
        repeat (FIFO_DEPTH + 2) rd_reg(OFS_DATA);
        rd_reg(OFS_LSR);
    endtask

    task automatic test_random_traffic();
        int          kind;
        int          n;
        logic [31:0] data;
        urf_in_t     item;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - QUIET_TAIL) begin
                idle_on = 1'b0;
            end
            kind = $urandom_range(0, 9);
            n = $urandom_range(1, 8);
            case (kind)
                0, 1: begin
                    // Character bursts, at times long enough to overrun.
                    n = $urandom_range(1, 80);
                    repeat (n) rx_char_in(8'($urandom_range(0, 255)));
                end
                2, 3: begin
                    n = $urandom_range(1, 70);
                    repeat (n) begin
                        if ($urandom_range(0, 7) == 0) begin
                            rd_reg(OFS_LSR);
                        end else begin
                            rd_reg(OFS_DATA);
                        end
                    end
                end
                4: begin
                    // Config A: the divisor latch shows through at 0x00 and 0x04.
                    data = $urandom;
                    data[LCR_CFG_A_BIT] = 1'b1;
                    if (data[7:0] == LCR_CFG_B) begin
                        data[7:0] = 8'h80;
                    end
                    wr_reg(OFS_LCR, data);
                    repeat (n) mode_window_access();
                    if ($urandom_range(0, 3) != 0) begin
                        data = $urandom;
                        data[LCR_CFG_A_BIT] = 1'b0;
                        wr_reg(OFS_LCR, data);
                    end
                end
                5: begin
                    // Config B: EFR shows through at 0x08.
                    data = $urandom;
                    data[7:0] = LCR_CFG_B;
                    wr_reg(OFS_LCR, data);
                    repeat (n) mode_window_access();
                    if ($urandom_range(0, 3) != 0) begin
                        data = $urandom;
                        data[LCR_CFG_A_BIT] = 1'b0;
                        wr_reg(OFS_LCR, data);
                    end
                end
                6: begin
                    wr_reg(OFS_FCR, $urandom);
                    rd_reg(OFS_FCR);
                end
                7: begin
                    repeat (n) begin
                        if ($urandom_range(0, 1) == 0) begin
                            rd_reg(pick_offset());
                        end else begin
                            wr_reg(pick_offset(), $urandom);
                        end
                    end
                end
                8: begin
                    // Unstructured items, including the unused opcode.
                    repeat (n) begin
                        item.opcode = 2'($urandom_range(0, 3));
                        item.offset = 12'($urandom_range(0, 4095));
                        item.wdata = $urandom;
                        item.rx_char = 8'($urandom_range(0, 255));
                        send_item(item);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        wr_reg(OFS_SYSC, $urandom);
                    end
                end
                default: begin
                    data = $urandom;
                    data[LCR_CFG_A_BIT] = 1'b0;
                    wr_reg(OFS_LCR, data);
                    repeat (n) wr_reg(OFS_DATA, $urandom);
                    rd_reg(OFS_LSR);
                end
            endcase
        end
    endtask

    // Result side: random ready bursts, plus one long hold-off on request.
    initial begin : result_sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
                run_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                run_left = $urandom_range(0, 30);
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expected result.
    always @(posedge aclk) begin : result_check
        urf_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no expected result: rdata %h tx_valid %b tx_char %h",
                       m_data.rdata, m_data.tx_valid, m_data.tx_char);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (m_data.rdata !== exp_res.rdata) begin
                    $error("rdata: expected %h, actual %h", exp_res.rdata, m_data.rdata);
                    error_count++;
                end
                if (m_data.tx_valid !== exp_res.tx_valid) begin
                    $error("tx_valid: expected %b, actual %b", exp_res.tx_valid, m_data.tx_valid);
                    error_count++;
                end
                if (m_data.tx_char !== exp_res.tx_char) begin
                    $error("tx_char: expected %h, actual %h", exp_res.tx_char, m_data.tx_char);
                    error_count++;
                end
            end
        end
    end

    // Stop the run if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("uart_register_file_rx_fifo verification failed");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        reset_shadow();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_register_access();
        test_access_modes();
        test_rx_fifo();
        test_soft_reset();
        test_backpressure();
        test_random_traffic();

        // Stop offering items and let the outstanding results drain.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("uart_register_file_rx_fifo verification clean");
        end else begin
            $display("uart_register_file_rx_fifo verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/urf_pkg.sv
design/urf_ram.sv
design/uart_register_file_rx_fifo.sv
design/urf_checker.sv
tb/sv/tb_uart_register_file_rx_fifo.sv
